/* hw/rtl/shp_pkg.sv */
// Package for the syslog header stream parser.
// Part codes, byte constants and the result record; no dependencies.
package shp_pkg;

  localparam int unsigned TagW = 4;
  localparam int unsigned NumW = 16;
  localparam int unsigned LevelW = 17;

  // Part codes, also used as the tag of a byte
  localparam logic [TagW-1:0] PART_OPEN = 4'd0;
  localparam logic [TagW-1:0] PART_PRI  = 4'd1;
  localparam logic [TagW-1:0] PART_VER  = 4'd2;
  localparam logic [TagW-1:0] PART_TS   = 4'd3;
  localparam logic [TagW-1:0] PART_HOST = 4'd4;
  localparam logic [TagW-1:0] PART_APP  = 4'd5;
  localparam logic [TagW-1:0] PART_PROC = 4'd6;
  localparam logic [TagW-1:0] PART_MSGID = 4'd7;
  localparam logic [TagW-1:0] PART_SD   = 4'd8;
  localparam logic [TagW-1:0] PART_MSG  = 4'd9;
  localparam logic [TagW-1:0] TAG_SEP   = 4'd10;

  localparam logic [7:0] CHAR_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CHAR_LBRK  = 8'h5B;  // '['
  localparam logic [7:0] CHAR_RBRK  = 8'h5D;  // ']'
  localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic signed [LevelW-1:0] LEVEL_MAX = 17'sh0FFFF;
  localparam logic signed [LevelW-1:0] LEVEL_MIN = 17'sh10000;
  localparam logic [NumW-1:0] NUM_SAT = 16'hFFFF;

  typedef struct packed {
    logic [TagW-1:0] part_tag;
    logic            done_res;
    logic            status;
    logic [NumW-1:0] priority_res;
    logic [NumW-1:0] version_num;
    logic [NumW-1:0] sd_length;
    logic [NumW-1:0] msg_offset;
    logic [NumW-1:0] msg_length;
  } result_t;

endpackage

/* hw/rtl/shp_in_if.sv */
// Byte input channel of the syslog header stream parser.
// Valid/ready handshake; no dependencies.
interface shp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_flag;

  modport source (output valid, output data_byte, output end_flag, input ready);
  modport sink   (input valid, input data_byte, input end_flag, output ready);
endinterface

/* hw/rtl/shp_out_if.sv */
// Result channel of the syslog header stream parser.
// Valid/ready handshake; no dependencies.
interface shp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  part_tag;
  logic        done_res;
  logic        status;
  logic [15:0] priority_res;
  logic [15:0] version_num;
  logic [15:0] sd_length;
  logic [15:0] msg_offset;
  logic [15:0] msg_length;

  modport source (output valid, output part_tag, output done_res, output status,
                  output priority_res, output version_num, output sd_length,
                  output msg_offset, output msg_length, input ready);
  modport sink   (input valid, input part_tag, input done_res, input status,
                  input priority_res, input version_num, input sd_length,
                  input msg_offset, input msg_length, output ready);
endinterface

/* hw/rtl/shp_step.sv */
// Parser state and per-byte next-state / result logic.
// Depends on shp_pkg.
module shp_step #(
  parameter int unsigned HEADER_MAX = 2048,
  parameter int unsigned MSG_MAX = 65535
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [7:0]      data_byte_i,
  input  logic            end_flag_i,
  output shp_pkg::result_t res_o
);
  import shp_pkg::*;

  logic [TagW-1:0]          part_q, part_d;
  logic [NumW-1:0]          pos_q, pos_d;
  logic [NumW-1:0]          acc_q, acc_d;
  logic                     seen_q, seen_d;
  logic [NumW-1:0]          pri_q, pri_d;
  logic [NumW-1:0]          ver_q, ver_d;
  logic signed [LevelW-1:0] level_q, level_d;
  logic [NumW-1:0]          sd_start_q, sd_start_d;
  logic                     err_q, err_d;
  logic [NumW-1:0]          sd_len_q, sd_len_d;
  logic [NumW-1:0]          msg_start_q, msg_start_d;

  logic [TagW-1:0] tag;
  logic            is_digit;
  logic [19:0]     acc_mul;
  logic            bad;
  logic [NumW-1:0] pos_inc;

  assign is_digit = (data_byte_i >= CHAR_ZERO) && (data_byte_i <= CHAR_NINE);
  assign pos_inc  = pos_q + 16'd1;
  // acc*10 + digit, saturated below
  assign acc_mul  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                  + {16'd0, data_byte_i[3:0]};

  always_comb begin
    part_d      = part_q;
    tag         = part_q;
    acc_d       = acc_q;
    seen_d      = seen_q;
    pri_d       = pri_q;
    ver_d       = ver_q;
    level_d     = level_q;
    sd_start_d  = sd_start_q;
    err_d       = err_q;
    sd_len_d    = sd_len_q;
    msg_start_d = msg_start_q;
    pos_d       = (pos_q == NUM_SAT) ? pos_q : pos_inc;

    if (!err_q) begin
      if (pos_q >= NumW'(MSG_MAX)) begin
        err_d = 1'b1;
      end
      if ((part_q <= PART_MSGID)
          && ((pos_q >= NumW'(HEADER_MAX)) || (data_byte_i == CHAR_NUL))) begin
        err_d = 1'b1;
      end
      unique case (part_q)
        PART_OPEN: begin
          if (data_byte_i == CHAR_LT) begin
            part_d = PART_PRI;
            acc_d  = '0;
            seen_d = 1'b0;
          end else begin
            err_d = 1'b1;
          end
        end
        PART_PRI, PART_VER: begin
          if (is_digit) begin
            acc_d  = (acc_mul > {4'd0, NUM_SAT}) ? NUM_SAT : acc_mul[NumW-1:0];
            seen_d = 1'b1;
          end else if (seen_q) begin
            tag = TAG_SEP;
            if (part_q == PART_PRI) begin
              pri_d = acc_q;
            end else begin
              ver_d = acc_q;
            end
            part_d = part_q + 4'd1;
            acc_d  = '0;
            seen_d = 1'b0;
          end else begin
            err_d = 1'b1;
          end
        end
        PART_TS, PART_HOST, PART_APP, PART_PROC, PART_MSGID: begin
          if (data_byte_i == CHAR_SPACE) begin
            tag = TAG_SEP;
            if (!seen_q) begin
              err_d = 1'b1;
            end else begin
              part_d = part_q + 4'd1;
              seen_d = 1'b0;
              if (part_q == PART_MSGID) begin
                sd_start_d = pos_inc;
                level_d    = '0;
              end
            end
          end else begin
            seen_d = 1'b1;
          end
        end
        PART_SD: begin
          if (data_byte_i == CHAR_LBRK) begin
            if (level_q < LEVEL_MAX) level_d = level_q + 17'sd1;
          end else if (data_byte_i == CHAR_RBRK) begin
            if (level_q > LEVEL_MIN) level_d = level_q - 17'sd1;
          end else if ((data_byte_i == CHAR_SPACE) && (level_q == '0)) begin
            tag         = TAG_SEP;
            sd_len_d    = pos_q - sd_start_q;
            msg_start_d = pos_inc;
            part_d      = PART_MSG;
          end
        end
        PART_MSG: ;
        default: err_d = 1'b1;
      endcase
    end
  end

  assign bad = err_d || (part_d != PART_MSG);

  always_comb begin
    res_o          = '0;
    res_o.part_tag = tag;
    if (end_flag_i) begin
      res_o.done_res = 1'b1;
      res_o.status   = bad;
      if (!bad) begin
        res_o.priority_res = pri_d;
        res_o.version_num  = ver_d;
        res_o.sd_length    = sd_len_d;
        res_o.msg_offset   = msg_start_d;
        res_o.msg_length   = pos_inc - msg_start_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q      <= PART_OPEN;
      pos_q       <= '0;
      acc_q       <= '0;
      seen_q      <= 1'b0;
      pri_q       <= '0;
      ver_q       <= '0;
      level_q     <= '0;
      sd_start_q  <= '0;
      err_q       <= 1'b0;
      sd_len_q    <= '0;
      msg_start_q <= '0;
    end else if (en_i) begin
      if (end_flag_i) begin
        // last byte: back to the start of a message
        part_q      <= PART_OPEN;
        pos_q       <= '0;
        acc_q       <= '0;
        seen_q      <= 1'b0;
        pri_q       <= '0;
        ver_q       <= '0;
        level_q     <= '0;
        sd_start_q  <= '0;
        err_q       <= 1'b0;
        sd_len_q    <= '0;
        msg_start_q <= '0;
      end else begin
        part_q      <= part_d;
        pos_q       <= pos_d;
        acc_q       <= acc_d;
        seen_q      <= seen_d;
        pri_q       <= pri_d;
        ver_q       <= ver_d;
        level_q     <= level_d;
        sd_start_q  <= sd_start_d;
        err_q       <= err_d;
        sd_len_q    <= sd_len_d;
        msg_start_q <= msg_start_d;
      end
    end
  end

endmodule

/* hw/rtl/syslog_header_stream_parser_core.sv */
// Top level of the syslog header stream parser: input register, step logic,
// result register. Depends on shp_pkg, shp_in_if, shp_out_if, shp_step.
//
//   channel     dir  request payload
//   in_chan_i   in   data_byte[8], end_flag[1]
//   out_chan_o  out  part_tag, done_res, status, priority_res, version_num,
//                    sd_length, msg_offset, msg_length
//
// One byte per cycle sustained while the output is not stalled. A byte
// waits in the input register; the parser state advances when it moves
// from the input register into the result register, which holds its
// result. Reset clears the valid flags and the parser state. A stalled
// output holds its result while one more byte waits in the input register.
module syslog_header_stream_parser_core #(
  parameter int unsigned HEADER_MAX = 2048,
  parameter int unsigned MSG_MAX = 65535
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  shp_in_if.sink    in_chan_i,
  shp_out_if.source out_chan_o
);
  import shp_pkg::*;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       end_q;
  logic       out_valid_q;
  result_t    res_q;
  result_t    step_res;
  logic       advance;

  assign advance = in_valid_q && (!out_valid_q || out_chan_o.ready);
  assign in_chan_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_chan_i.ready) begin
      in_valid_q <= in_chan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan_i.ready && in_chan_i.valid) begin
      byte_q <= in_chan_i.data_byte;
      end_q  <= in_chan_i.end_flag;
    end
  end

  shp_step #(
    .HEADER_MAX(HEADER_MAX),
    .MSG_MAX   (MSG_MAX)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .data_byte_i(byte_q),
    .end_flag_i (end_q),
    .res_o      (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_chan_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign out_chan_o.valid        = out_valid_q;
  assign out_chan_o.part_tag     = res_q.part_tag;
  assign out_chan_o.done_res     = res_q.done_res;
  assign out_chan_o.status       = res_q.status;
  assign out_chan_o.priority_res = res_q.priority_res;
  assign out_chan_o.version_num  = res_q.version_num;
  assign out_chan_o.sd_length    = res_q.sd_length;
  assign out_chan_o.msg_offset   = res_q.msg_offset;
  assign out_chan_o.msg_length   = res_q.msg_length;

endmodule
